>>> design/rlet_pkg.sv
package rlet_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam logic [31:0] MAX_BYTES_RST = 32'd16777216;

    localparam logic [2:0] OP_GET     = 3'd0;
    localparam logic [2:0] OP_APPEND  = 3'd1;
    localparam logic [2:0] OP_MARK_OK = 3'd2;
    localparam logic [2:0] OP_MARK_FL = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [3:0]  entry_index;
        logic [15:0] length;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] result_index;
        logic       writer;
    } rsp_t;
endpackage

>>> design/refcounted_lru_entry_table.sv
// Reference-counted LRU entry table. get looks up a 64-bit key across all
// ENTRIES entries; a hit bumps the count (saturating at 255) and refreshes the
// time, a miss allocates the first free entry or else the unreferenced entry
// with the oldest time (ties to the highest index), status 1 if none. append,
// mark complete, mark failed and release address entry_index directly. A
// front queue of two requests decouples input from the execute sequencer. A
// get runs start, a scan of one entry per cycle, execute, output; other ops
// skip the scan. One transaction is executed at a time. max_bytes is written
// over cfg; the user, not the block, must do so only while the block idles.
module refcounted_lru_entry_table
    import rlet_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_entry_index,
    input  logic [15:0] s_length,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_result_index,
    output logic        m_writer
);
    logic [31:0] max_bytes_reg;
    logic        q_valid, q_pop;
    req_t        q_head;
    rsp_t        rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) max_bytes_reg <= MAX_BYTES_RST;
        else if (cfg_valid) max_bytes_reg <= cfg_data;
    end

    rlet_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_key, .s_entry_index,
        .s_length, .s_now, .q_valid, .q_pop, .q_head
    );

    rlet_back #(.ENTRIES(ENTRIES)) u_back (
        .aclk, .aresetn, .max_bytes(max_bytes_reg), .q_valid, .q_pop, .q_head,
        .m_valid, .m_ready, .m_rsp(rsp)
    );

    assign m_status       = rsp.status;
    assign m_result_index = rsp.result_index;
    assign m_writer       = rsp.writer;
endmodule

>>> design/rlet_front.sv
// Input stage: pushes the request into a two-entry queue of registers.
module rlet_front
    import rlet_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_entry_index,
    input  logic [15:0] s_length,
    input  logic [31:0] s_now,
    output logic        q_valid,
    input  logic        q_pop,
    output req_t        q_head
);
    req_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push  ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= '{op: s_op, key: s_key, entry_index: s_entry_index,
                                 length: s_length, now: s_now};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push lost");
endmodule

>>> design/rlet_back.sv
// Executes requests: for a get, scans entries one per cycle for hit/free/oldest.
module rlet_back
    import rlet_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] max_bytes,
    input  logic        q_valid,
    output logic        q_pop,
    input  req_t        q_head,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_EXEC = 3'd2, S_OUT = 3'd3;

    logic [ENTRIES-1:0] valid_reg, comp_reg, fail_reg;
    logic [63:0] key_reg  [ENTRIES];
    logic [7:0]  ref_reg  [ENTRIES];
    logic [31:0] time_reg [ENTRIES];
    logic [31:0] size_reg [ENTRIES];

    logic [2:0]  st_reg;
    logic [IW:0] ptr_reg;
    logic        hit_reg, free_reg, vic_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, vic_idx_reg;
    logic [31:0] oldest_reg;
    rsp_t        rsp_reg, rsp_next;
    logic [IW-1:0] p;
    logic [IW-1:0] ai;
    logic [IW-1:0] alloc_idx;
    logic        in_range;
    logic [32:0] need;

    assign p         = ptr_reg[IW-1:0];
    assign q_pop     = (st_reg == S_EXEC);
    assign m_valid   = (st_reg == S_OUT);
    assign m_rsp     = rsp_reg;
    assign in_range  = ({28'd0, q_head.entry_index} < 32'(ENTRIES));
    assign ai        = IW'(q_head.entry_index);
    assign need      = {1'b0, size_reg[ai]} + {17'd0, q_head.length};
    assign alloc_idx = free_reg ? free_idx_reg : vic_idx_reg;

    // result of the request at the queue head, taken in S_EXEC
    always_comb begin
        rsp_next = '{status: ST_OK, result_index: 4'd0, writer: 1'b0};
        if (q_head.op == OP_GET) begin
            if (hit_reg) begin
                rsp_next.result_index = 4'(hit_idx_reg);
            end else if (free_reg || vic_reg) begin
                rsp_next.result_index = 4'(alloc_idx);
                rsp_next.writer       = 1'b1;
            end else begin
                rsp_next.status = ST_NOROOM;
            end
        end else if (in_range && q_head.op == OP_APPEND && q_head.length != 16'd0 &&
                     (fail_reg[ai] || need > {1'b0, max_bytes})) begin
            rsp_next.status = ST_FAILED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            valid_reg <= '0;
            comp_reg  <= '0;
            fail_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                key_reg[i]  <= '0;
                ref_reg[i]  <= '0;
                time_reg[i] <= '0;
                size_reg[i] <= '0;
            end
        end else begin
            case (st_reg)
                S_IDLE: if (q_valid) begin
                    ptr_reg  <= '0;
                    hit_reg  <= 1'b0;
                    free_reg <= 1'b0;
                    vic_reg  <= 1'b0;
                    st_reg   <= (q_head.op == OP_GET) ? S_SCAN : S_EXEC;
                end
                S_SCAN: begin
                    if (valid_reg[p] && key_reg[p] == q_head.key && !hit_reg) begin
                        hit_reg <= 1'b1; hit_idx_reg <= p;
                    end
                    if (!valid_reg[p] && !free_reg) begin
                        free_reg <= 1'b1; free_idx_reg <= p;
                    end
                    // <= keeps the highest index on a tie
                    if (valid_reg[p] && ref_reg[p] == 8'd0 &&
                        (!vic_reg || time_reg[p] <= oldest_reg)) begin
                        vic_reg <= 1'b1; vic_idx_reg <= p; oldest_reg <= time_reg[p];
                    end
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == (IW+1)'(ENTRIES-1)) st_reg <= S_EXEC;
                end
                S_EXEC: begin
                    rsp_reg <= rsp_next;
                    st_reg  <= S_OUT;
                    if (q_head.op == OP_GET) begin
                        if (hit_reg) begin
                            if (ref_reg[hit_idx_reg] != 8'hFF)
                                ref_reg[hit_idx_reg] <= ref_reg[hit_idx_reg] + 8'd1;
                            time_reg[hit_idx_reg] <= q_head.now;
                        end else if (free_reg || vic_reg) begin
                            valid_reg[alloc_idx] <= 1'b1;
                            key_reg[alloc_idx]   <= q_head.key;
                            ref_reg[alloc_idx]   <= 8'd1;
                            time_reg[alloc_idx]  <= q_head.now;
                            size_reg[alloc_idx]  <= '0;
                            comp_reg[alloc_idx]  <= 1'b0;
                            fail_reg[alloc_idx]  <= 1'b0;
                        end
                    end else if (in_range) begin
                        case (q_head.op)
                            OP_APPEND: if (q_head.length != 16'd0 && !fail_reg[ai]) begin
                                if (need > {1'b0, max_bytes}) begin
                                    fail_reg[ai] <= 1'b1;
                                end else begin
                                    size_reg[ai] <= need[31:0];
                                    time_reg[ai] <= q_head.now;
                                end
                            end
                            OP_MARK_OK: begin
                                comp_reg[ai] <= 1'b1;
                                time_reg[ai] <= q_head.now;
                            end
                            OP_MARK_FL: fail_reg[ai] <= 1'b1;
                            OP_RELEASE: if (ref_reg[ai] != 8'd0)
                                ref_reg[ai] <= ref_reg[ai] - 8'd1;
                            default: ;
                        endcase
                    end
                end
                S_OUT: if (m_ready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_EXEC) |=> (st_reg == S_OUT))
        else $error("exec not followed by output");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_OUT && !m_ready) |=> (st_reg == S_OUT && $stable(rsp_reg)))
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_rsp.writer && m_rsp.status != ST_OK))
        else $error("writer with error status");
endmodule

>>> test/rlet_checker.sv
module rlet_checker
    import rlet_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_entry_index,
    input  logic [15:0] s_length,
    input  logic [31:0] s_now,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [3:0]  m_result_index,
    input  logic        m_writer,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = 16;

    logic [31:0] lim;
    logic        t_valid [N];
    logic [63:0] t_key   [N];
    logic [7:0]  t_refs  [N];
    logic [31:0] t_time  [N];
    logic [31:0] t_size  [N];
    logic        t_done  [N];
    logic        t_fail  [N];

    rsp_t expected_rsp [$];

    assign pending = expected_rsp.size();

    function automatic int pick_victim();
        int best;
        logic [31:0] oldest;
        best = -1;
        oldest = '0;
        for (int i = 0; i < N; i++)
            if (!t_valid[i]) return i;
        for (int i = 0; i < N; i++)
            if (t_refs[i] == 0 && (best < 0 || t_time[i] <= oldest)) begin
                oldest = t_time[i];
                best = i;
            end
        return best;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int hit;
        int v;
        logic [32:0] need;
        o = '0;
        hit = -1;
        if (r.op == OP_GET) begin
            for (int i = 0; i < N; i++)
                if (hit < 0 && t_valid[i] && t_key[i] == r.key) hit = i;
            if (hit >= 0) begin
                if (t_refs[hit] != 8'hFF) t_refs[hit]++;
                t_time[hit] = r.now;
                o.result_index = hit[3:0];
            end else begin
                v = pick_victim();
                if (v < 0) begin
                    o.status = ST_NOROOM;
                end else begin
                    t_valid[v] = 1'b1;
                    t_key[v] = r.key;
                    t_refs[v] = 8'd1;
                    t_time[v] = r.now;
                    t_size[v] = '0;
                    t_done[v] = 1'b0;
                    t_fail[v] = 1'b0;
                    o.result_index = v[3:0];
                    o.writer = 1'b1;
                end
            end
        end else if (r.op == OP_APPEND) begin
            if (r.length != 0) begin
                if (t_fail[r.entry_index]) begin
                    o.status = ST_FAILED;
                end else begin
                    need = {1'b0, t_size[r.entry_index]} + {17'd0, r.length};
                    if (need > {1'b0, lim}) begin
                        t_fail[r.entry_index] = 1'b1;
                        o.status = ST_FAILED;
                    end else begin
                        t_size[r.entry_index] = need[31:0];
                        t_time[r.entry_index] = r.now;
                    end
                end
            end
        end else if (r.op == OP_MARK_OK) begin
            t_done[r.entry_index] = 1'b1;
            t_time[r.entry_index] = r.now;
        end else if (r.op == OP_MARK_FL) begin
            t_fail[r.entry_index] = 1'b1;
        end else if (r.op == OP_RELEASE) begin
            if (t_refs[r.entry_index] != 0) t_refs[r.entry_index]--;
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        rsp_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            lim <= MAX_BYTES_RST;
            for (int i = 0; i < N; i++) begin
                t_valid[i] = 1'b0; t_key[i] = '0; t_refs[i] = '0; t_time[i] = '0;
                t_size[i] = '0; t_done[i] = 1'b0; t_fail[i] = 1'b0;
            end
            expected_rsp.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) lim <= cfg_data;
            if (s_valid && s_ready)
                expected_rsp.push_back(apply_request(
                    '{s_op, s_key, s_entry_index, s_length, s_now}));
            if (m_valid && m_ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("unexpected result transaction");
                    errs++;
                end else begin
                    e = expected_rsp.pop_front();
                    if (m_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_status);
                        errs++;
                    end
                    if (m_result_index !== e.result_index) begin
                        $error("result_index expected %0d actual %0d",
                               e.result_index, m_result_index);
                        errs++;
                    end
                    if (m_writer !== e.writer) begin
                        $error("writer expected %0d actual %0d",
                               e.writer, m_writer);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

>>> test/testbench.sv
module testbench
    import rlet_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [63:0] s_key = '0;
    logic [3:0]  s_entry_index = '0;
    logic [15:0] s_length = '0;
    logic [31:0] s_now = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_result_index;
    logic        m_writer;
    int          fail_count;
    int          pending;

    // idle percentages per phase, sender and receiver
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off  = 1'b0;   // long receiver stall request
    logic [31:0] clock_now = '0;
    logic [63:0] key_pool [8];

    refcounted_lru_entry_table DUT (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_op, .s_key, .s_entry_index, .s_length, .s_now,
        .m_valid, .m_ready, .m_status, .m_result_index, .m_writer
    );

    rlet_checker u_checker (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_op, .s_key, .s_entry_index, .s_length, .s_now,
        .m_valid, .m_ready, .m_status, .m_result_index, .m_writer,
        .fail_count, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // hard stop for a hung run
    initial begin
        #20ms;
        $display("refcounted_lru_entry_table verification failed");
        $finish;
    end

    // receiver: random stalls, or a long hold-off while the sender keeps going
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                for (n = 0; n < 300; n++) @(posedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one request transaction; valid stays up across back-to-back items
    task automatic send_req(logic [2:0] op, logic [63:0] key, logic [3:0] idx,
                            logic [15:0] len, logic [31:0] now);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op; s_key <= key; s_entry_index <= idx;
        s_length <= len; s_now <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_limit(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // gets (the most frequent op) on a small key pool so hits, refcounts and eviction happen
    task automatic random_req();
        logic [2:0] op;
        int r;
        r = $urandom_range(99);
        clock_now = clock_now + $urandom_range(3);
        if (r < 40) op = OP_GET;
        else if (r < 62) op = OP_APPEND;
        else if (r < 70) op = OP_MARK_OK;
        else if (r < 76) op = OP_MARK_FL;
        else if (r < 97) op = OP_RELEASE;
        else op = 3'($urandom_range(7));
        send_req(op,
                 ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)],
                 4'($urandom_range(15)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64)),
                 ($urandom_range(19) == 0) ? $urandom : clock_now);
    endtask

    initial begin
        logic [31:0] limits [4];
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        limits = '{32'd1, 32'd200, 32'hFFFF_FFFF, 32'd5000};
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // directed: default limit; fill all entries, overflow, edges
        for (int i = 0; i < 16; i++)
            send_req(OP_GET, 64'(i) * 64'h1111, 4'(i), '0, 32'(i));
        send_req(OP_GET, '1, 4'd0, '0, '1);               // all referenced: no room
        send_req(OP_GET, 64'h0, 4'd0, '0, 32'd100);        // hit
        send_req(OP_APPEND, '0, 4'd15, 16'hFFFF, '1);
        send_req(OP_APPEND, '0, 4'd3, 16'd0, 32'd7);       // zero length
        send_req(OP_MARK_FL, '0, 4'd3, '0, '0);
        send_req(OP_APPEND, '0, 4'd3, 16'd5, 32'd8);       // failed entry
        send_req(OP_MARK_OK, '0, 4'd4, '0, 32'd9);
        send_req(OP_RELEASE, '0, 4'd5, '0, '0);
        send_req(OP_RELEASE, '0, 4'd5, '0, '0);            // release at zero
        send_req(3'd7, '1, 4'd15, '1, '1);                 // unused op
        for (int i = 0; i < 6; i++)
            send_req(OP_RELEASE, '0, 4'($urandom_range(15)), '0, '0);
        send_req(OP_GET, '1, 4'd0, '0, '1);                // eviction
        drain();

        // release many references so saturation and LRU reuse are reachable
        for (int i = 0; i < 16; i++) begin
            send_req(OP_RELEASE, '0, 4'(i), '0, '0);
            send_req(OP_RELEASE, '0, 4'(i), '0, '0);
        end
        for (int i = 0; i < 260; i++) send_req(OP_GET, 64'h0, '0, '0, 32'd5);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_limit(limits[ph]);
            case (ph)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 52; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 52; end
                default: begin send_idle = 16; recv_idle = 16; end
            endcase
            if (ph == 0) hold_off = 1'b1;
            for (int i = 0; i < 180; i++) random_req();
            drain();
        end

        if (fail_count == 0)
            $display("refcounted_lru_entry_table verification clean");
        else
            $display("refcounted_lru_entry_table verification failed");
        $finish;
    end
endmodule

>>> files.f
design/rlet_pkg.sv
design/rlet_front.sv
design/rlet_back.sv
design/refcounted_lru_entry_table.sv
test/rlet_checker.sv
test/testbench.sv
